FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // decoder phases
    typedef enum logic [2:0] {
        PH_PLAIN    = 3'd0,
        PH_ESC      = 3'd1,
        PH_HEX      = 3'd2,
        PH_PEND     = 3'd3,
        PH_PEND_ESC = 3'd4,
        PH_HEX2     = 3'd5
    } phase_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_CLOSE   = 2'd1,
        ST_BAD_ESC = 2'd2,
        ST_UNTERM  = 2'd3
    } status_t;

    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam int QUEUE_DEPTH_DEF = 4;

    // one run of result bytes sharing a status
    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        status_t         status;
        logic [2:0]      cnt;     // 0 = empty
    } seg_t;

    // everything one input beat produces: seg0 then seg1
    typedef struct packed {
        seg_t seg1;
        seg_t seg0;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        phase_t phase;
        logic   pend;
    } front_stat_t;

    function automatic seg_t one_seg(input logic [7:0] b, input status_t st);
        seg_t s;
        s          = '0;
        s.bytes[0] = b;
        s.status   = st;
        s.cnt      = 3'd1;
        return s;
    endfunction

    // 16 = not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

    function automatic seg_t escape_seg(input logic [7:0] e);
        seg_t s;
        s = one_seg(e, ST_DATA);
        unique case (e)
            CHR_QUOTE:  s.bytes[0] = 8'h22;
            CHR_BSLASH: s.bytes[0] = 8'h5C;
            CHR_SLASH:  s.bytes[0] = 8'h2F;
            CHR_B:      s.bytes[0] = 8'h08;
            CHR_F:      s.bytes[0] = 8'h0C;
            CHR_N:      s.bytes[0] = 8'h0A;
            CHR_R:      s.bytes[0] = 8'h0D;
            CHR_T:      s.bytes[0] = 8'h09;
            default: begin
                // unknown escape: backslash and the byte pass through
                s.bytes[0] = CHR_BSLASH;
                s.bytes[1] = e;
                s.cnt      = 3'd2;
            end
        endcase
        return s;
    endfunction

    function automatic seg_t utf8_seg(input logic [20:0] cp);
        seg_t s;
        s        = '0;
        s.status = ST_DATA;
        if (cp < 21'h80) begin
            s.bytes[0] = cp[7:0];
            s.cnt      = 3'd1;
        end else if (cp < 21'h800) begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.cnt      = 3'd2;
        end else if (cp < SUPP_BASE) begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.cnt      = 3'd3;
        end else begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.cnt      = 3'd4;
        end
        return s;
    endfunction

    function automatic logic is_high_sur(input logic [15:0] cp);
        return cp[15:10] == 6'b110110;
    endfunction

    function automatic logic is_low_sur(input logic [15:0] cp);
        return cp[15:10] == 6'b110111;
    endfunction

endpackage

`default_nettype wire

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one raw byte per beat, builds the result list.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        beat,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_eoi,
    output q_push_t          q_push,
    output front_stat_t      fstat
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic [15:0] high_sur_reg, high_sur_next;
    logic        sur_pend_reg, sur_pend_next;

    logic [4:0]  digit;
    logic [15:0] acc_shift;
    logic [2:0]  hc_inc;
    logic [20:0] pair_cp;
    cmd_t        cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_PLAIN;
            hex_count_reg  <= '0;
            code_accum_reg <= '0;
            high_sur_reg   <= '0;
            sur_pend_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
            high_sur_reg   <= high_sur_next;
            sur_pend_reg   <= sur_pend_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        high_sur_next   = high_sur_reg;
        sur_pend_next   = sur_pend_reg;
        cmd             = '0;

        digit     = hex_value(in_byte);
        acc_shift = {code_accum_reg[11:0], digit[3:0]};
        hc_inc    = hex_count_reg + 3'd1;
        pair_cp   = SUPP_BASE + {1'b0, high_sur_reg[9:0], acc_shift[9:0]};

        if (beat) begin
            if (in_eoi) begin
                cmd.seg0 = one_seg(8'h00,
                    (phase_reg == PH_HEX || phase_reg == PH_HEX2) ? ST_BAD_ESC : ST_UNTERM);
                phase_next      = PH_PLAIN;
                hex_count_next  = '0;
                code_accum_next = '0;
                high_sur_next   = '0;
                sur_pend_next   = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_ESC: begin
                        if (in_byte == CHR_U) begin
                            phase_next      = PH_HEX;
                            hex_count_next  = '0;
                            code_accum_next = '0;
                        end else begin
                            cmd.seg0   = escape_seg(in_byte);
                            phase_next = PH_PLAIN;
                        end
                    end
                    PH_HEX, PH_HEX2: begin
                        if (digit[4]) begin
                            cmd.seg0        = one_seg(8'h00, ST_BAD_ESC);
                            phase_next      = PH_PLAIN;
                            hex_count_next  = '0;
                            code_accum_next = '0;
                            high_sur_next   = '0;
                            sur_pend_next   = 1'b0;
                        end else begin
                            code_accum_next = acc_shift;
                            hex_count_next  = hc_inc;
                            if (hc_inc[2]) begin
                                hex_count_next  = '0;
                                code_accum_next = '0;
                                if (phase_reg == PH_HEX) begin
                                    if (is_high_sur(acc_shift)) begin
                                        high_sur_next = acc_shift;
                                        sur_pend_next = 1'b1;
                                        phase_next    = PH_PEND;
                                    end else begin
                                        cmd.seg0   = utf8_seg({5'd0, acc_shift});
                                        phase_next = PH_PLAIN;
                                    end
                                end else if (is_low_sur(acc_shift)) begin
                                    // surrogate pair -> one supplementary code point
                                    cmd.seg0      = utf8_seg(pair_cp);
                                    high_sur_next = '0;
                                    sur_pend_next = 1'b0;
                                    phase_next    = PH_PLAIN;
                                end else begin
                                    // lone high sur, then new code (held if high)
                                    cmd.seg0      = utf8_seg({5'd0, high_sur_reg});
                                    high_sur_next = '0;
                                    sur_pend_next = 1'b0;
                                    if (is_high_sur(acc_shift)) begin
                                        high_sur_next = acc_shift;
                                        sur_pend_next = 1'b1;
                                        phase_next    = PH_PEND;
                                    end else begin
                                        cmd.seg1   = utf8_seg({5'd0, acc_shift});
                                        phase_next = PH_PLAIN;
                                    end
                                end
                            end
                        end
                    end
                    PH_PEND: begin
                        if (in_byte == CHR_BSLASH) begin
                            phase_next = PH_PEND_ESC;
                        end else begin
                            cmd.seg0      = utf8_seg({5'd0, high_sur_reg});
                            high_sur_next = '0;
                            sur_pend_next = 1'b0;
                            phase_next    = PH_PLAIN;
                            if (in_byte == CHR_QUOTE) begin
                                cmd.seg1        = one_seg(8'h00, ST_CLOSE);
                                hex_count_next  = '0;
                                code_accum_next = '0;
                            end else begin
                                cmd.seg1 = one_seg(in_byte, ST_DATA);
                            end
                        end
                    end
                    PH_PEND_ESC: begin
                        if (in_byte == CHR_U) begin
                            phase_next      = PH_HEX2;
                            hex_count_next  = '0;
                            code_accum_next = '0;
                        end else begin
                            cmd.seg0      = utf8_seg({5'd0, high_sur_reg});
                            cmd.seg1      = escape_seg(in_byte);
                            high_sur_next = '0;
                            sur_pend_next = 1'b0;
                            phase_next    = PH_PLAIN;
                        end
                    end
                    default: begin
                        // plain phase; unused codes behave the same
                        if (in_byte == CHR_QUOTE) begin
                            cmd.seg0        = one_seg(8'h00, ST_CLOSE);
                            phase_next      = PH_PLAIN;
                            hex_count_next  = '0;
                            code_accum_next = '0;
                            high_sur_next   = '0;
                            sur_pend_next   = 1'b0;
                        end else if (in_byte == CHR_BSLASH) begin
                            phase_next = PH_ESC;
                        end else begin
                            cmd.seg0   = one_seg(in_byte, ST_DATA);
                            phase_next = PH_PLAIN;
                        end
                    end
                endcase
            end
        end
    end

    assign q_push.push = beat && (cmd.seg0.cnt != 3'd0);
    assign q_push.cmd  = cmd;
    assign fstat.phase = phase_reg;
    assign fstat.pend  = sur_pend_reg;

endmodule

`default_nettype wire

FILE: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small command FIFO between the decoder and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_push_t q_push,
    input  wire logic    pop,
    output q_head_t      q_head,
    output logic         full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            mem[wr_ptr_reg] <= q_push.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push.push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_push.push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !q_push.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.cmd   = mem[rd_ptr_reg];
    assign full         = (count_reg == CNT_FULL);

endmodule

`default_nettype wire

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: walks each command's bytes into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire q_head_t    q_head,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    status_t    status_reg;
    logic       last_reg;

    logic [3:0] total;
    logic       in_seg1;
    logic [2:0] off;
    logic [7:0] cur_byte;
    status_t    cur_status;
    logic       cur_last;
    logic       load;

    always_comb begin
        total   = {1'b0, q_head.cmd.seg0.cnt} + {1'b0, q_head.cmd.seg1.cnt};
        in_seg1 = (idx_reg >= q_head.cmd.seg0.cnt);
        off     = idx_reg - q_head.cmd.seg0.cnt;
        if (in_seg1) begin
            cur_byte   = q_head.cmd.seg1.bytes[off[1:0]];
            cur_status = q_head.cmd.seg1.status;
        end else begin
            cur_byte   = q_head.cmd.seg0.bytes[idx_reg[1:0]];
            cur_status = q_head.cmd.seg0.status;
        end
        cur_last = (({1'b0, idx_reg} + 4'd1) == total);
        load     = q_head.valid && (!valid_reg || m_tready);
        pop      = load && cur_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= cur_last ? 3'd0 : idx_reg + 3'd1;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg   <= cur_byte;
            status_reg <= cur_status;
            last_reg   <= cur_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: design/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper: raw body bytes in, UTF-8 bytes and status out.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata           | tuser       | tlast
//  --------+-----+-----------------+-------------+-----------------------------
//  s_      | in  | [7:0] in_byte   | -           | end_of_input
//  m_      | out | [7:0] out_byte  | [1:0] status| last result of an input beat
//
//  Input beats are taken one per cycle as long as the command queue has room;
//  each beat produces 0..6 result beats, drained one per cycle by the
//  serializer unless the output stage is stalled; a command holds its queue
//  slot until its last byte is loaded into the output register.
//  Reset (aresetn low, synchronous) returns the decoder to the plain phase
//  and empties the queue and the output register.
//  m_tready low stalls only the output stage; input keeps flowing until the
//  queue fills.
//
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_input

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [1:0] status
    output logic            m_tlast    // last result of the input beat
);

    q_push_t     q_push;
    q_head_t     q_head;
    front_stat_t fstat;
    logic        q_full;
    logic        pop;
    logic        s_beat;

    // front stalls only on a full queue
    assign s_tready = !q_full;
    assign s_beat   = s_tvalid && s_tready;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (s_beat),
        .in_byte (s_tdata),
        .in_eoi  (s_tlast),
        .q_push  (q_push),
        .fstat   (fstat)
    );

    jsu_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .pop     (pop),
        .q_head  (q_head),
        .full    (q_full)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a surrogate is pending exactly in the phases that wait for its partner
    a_pend_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.pend == (fstat.phase == PH_PEND || fstat.phase == PH_PEND_ESC ||
                       fstat.phase == PH_HEX2))
        else $error("surrogate pending flag out of step with phase");

    // status beats carry a zero byte
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DATA) |-> (m_tdata == 8'h00))
        else $error("status beat with nonzero data");

    // close and error beats always end their input's burst
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DATA) |-> m_tlast)
        else $error("status beat not marked last");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push.push)
        else $error("command queue overflow");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of json_string_unescape_utf8. A short table of body
// bytes hits the field extremes, named, unknown and \u escapes and both error paths;
// a generator then builds mostly well-formed string bodies (plain runs,
// escapes, \u sequences, surrogate pairs, lone surrogates, closes, end of
// text) mixed with noise. Both sides idle at random. Every accepted input
// beat runs through an in-bench decoder; each result beat is checked against
// the oldest predicted one.
// ----------------------------------------------------------------------------

module testbench;
    import jsu_pkg::*;

    localparam int N_PLAN       = 27;    // rows in the directed table
    localparam int RANDOM_BEATS = 420;   // generator stops past this count
    localparam int HOLD_CYCLES  = 100;   // long result-side hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int MAX_PRINTS   = 40;

    // one input beat as offered, with an optional typed-in expectation
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       fixed;        // 1: the single result below is expected
        logic [7:0] want_data;
        status_t    want_status;
    } stim_t;

    // one result beat
    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } out_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [1:0] m_tuser;            // [1:0] status
    logic       m_tlast;            // last result of the input beat

    json_string_unescape_utf8 u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    stim_t      body_inflight[$];   // offered beats, oldest awaits acceptance
    out_beat_t  utf8_due[$];        // predicted result beats, oldest first
    out_beat_t  decoded[$];         // results of the beat being predicted

    int unsigned n_offered   = 0;
    int unsigned n_in        = 0;
    int unsigned n_out       = 0;
    int unsigned n_close     = 0;
    int unsigned n_bad       = 0;
    int unsigned n_unterm    = 0;
    int unsigned n_pairs     = 0;
    int unsigned n_holds     = 0;
    int unsigned n_errors    = 0;
    int unsigned idle_cycles = 0;

    // "calm" stretches: neither side idles
    logic        calm      = 1'b0;
    int unsigned calm_left = 20;
    logic        hold_req  = 1'b0;

    logic [7:0] esc_chars [8];

    // ------------------------------------------------------------------------
    // Decoder model: own copy of the decoder state
    // ------------------------------------------------------------------------
    phase_t      dec_phase = PH_PLAIN;
    logic [2:0]  nib_count = '0;
    logic [15:0] code_acc  = '0;
    logic [15:0] hi_sur    = '0;

    task automatic emit(input logic [7:0] d, input status_t st);
        out_beat_t o;
        o = '{data: d, status: st, last: 1'b0};
        decoded.insert(decoded.size(), o);
    endtask

    task automatic emit_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], ST_DATA);
        end else if (cp < 21'h800) begin
            emit(8'hC0 | 8'(cp >> 6), ST_DATA);
            emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
        end else if (cp < 21'h10000) begin
            emit(8'hE0 | 8'(cp >> 12), ST_DATA);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_DATA);
            emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
        end else begin
            emit(8'hF0 | 8'((cp >> 18) & 21'h07), ST_DATA);
            emit(8'h80 | 8'((cp >> 12) & 21'h3F), ST_DATA);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_DATA);
            emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
        end
    endtask

    task automatic clear_decoder();
        dec_phase = PH_PLAIN;
        nib_count = '0;
        code_acc  = '0;
        hi_sur    = '0;
    endtask

    // lone high surrogate goes out as its own 3-byte sequence
    task automatic flush_pending();
        emit_cp(21'(hi_sur));
        hi_sur = '0;
    endtask

    task automatic take_plain(input logic [7:0] b);
        if (b == CHR_QUOTE) begin
            emit(8'h00, ST_CLOSE);
            clear_decoder();
        end else if (b == CHR_BSLASH) begin
            dec_phase = PH_ESC;
        end else begin
            emit(b, ST_DATA);
            dec_phase = PH_PLAIN;
        end
    endtask

    task automatic take_escape(input logic [7:0] e);
        case (e)
            CHR_QUOTE:  emit(8'h22, ST_DATA);
            CHR_BSLASH: emit(8'h5C, ST_DATA);
            CHR_SLASH:  emit(8'h2F, ST_DATA);
            CHR_B:      emit(8'h08, ST_DATA);
            CHR_F:      emit(8'h0C, ST_DATA);
            CHR_N:      emit(8'h0A, ST_DATA);
            CHR_R:      emit(8'h0D, ST_DATA);
            CHR_T:      emit(8'h09, ST_DATA);
            default: begin
                // unknown escape passes through as two bytes
                emit(CHR_BSLASH, ST_DATA);
                emit(e, ST_DATA);
            end
        endcase
        dec_phase = PH_PLAIN;
    endtask

    task automatic take_code(input logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            hi_sur    = cp;
            dec_phase = PH_PEND;
        end else begin
            emit_cp(21'(cp));
            dec_phase = PH_PLAIN;
        end
    endtask

    // fills decoded with the result beats of one input beat
    task automatic unescape_predict(input logic [7:0] b, input logic eoi);
        logic [4:0]  nib;
        logic [15:0] cp;
        logic [20:0] pair_cp;
        decoded.delete();
        if (eoi) begin
            emit(8'h00, (dec_phase == PH_HEX || dec_phase == PH_HEX2) ? ST_BAD_ESC : ST_UNTERM);
            clear_decoder();
        end else begin
            case (dec_phase)
                PH_ESC: begin
                    if (b == CHR_U) begin
                        dec_phase = PH_HEX;
                        nib_count = '0;
                        code_acc  = '0;
                    end else begin
                        take_escape(b);
                    end
                end
                PH_HEX, PH_HEX2: begin
                    if (b >= "0" && b <= "9")      nib = 5'(b - "0");
                    else if (b >= "a" && b <= "f") nib = 5'(b - "a" + 8'd10);
                    else if (b >= "A" && b <= "F") nib = 5'(b - "A" + 8'd10);
                    else                           nib = 5'd16;
                    if (nib[4]) begin
                        emit(8'h00, ST_BAD_ESC);
                        clear_decoder();
                    end else begin
                        code_acc  = {code_acc[11:0], nib[3:0]};
                        nib_count = nib_count + 3'd1;
                        if (nib_count >= 3'd4) begin
                            cp        = code_acc;
                            nib_count = '0;
                            code_acc  = '0;
                            if (dec_phase == PH_HEX) begin
                                take_code(cp);
                            end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                                pair_cp = 21'h10000 + ((21'(hi_sur) - 21'hD800) << 10)
                                        + (21'(cp) - 21'hDC00);
                                hi_sur  = '0;
                                emit_cp(pair_cp);
                                dec_phase = PH_PLAIN;
                                n_pairs++;
                            end else begin
                                flush_pending();
                                take_code(cp);
                            end
                        end
                    end
                end
                PH_PEND: begin
                    if (b == CHR_BSLASH) begin
                        dec_phase = PH_PEND_ESC;
                    end else begin
                        flush_pending();
                        dec_phase = PH_PLAIN;
                        take_plain(b);
                    end
                end
                PH_PEND_ESC: begin
                    if (b == CHR_U) begin
                        dec_phase = PH_HEX2;
                        nib_count = '0;
                        code_acc  = '0;
                    end else begin
                        flush_pending();
                        take_escape(b);
                    end
                end
                default: take_plain(b);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: prediction on input beats, checking on result beats.
    // Both in one process so that their relative order is fixed.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        stim_t     d;
        out_beat_t r;
        logic      busy;
        if (aresetn) begin
            busy = 1'b0;
            if (s_tvalid && s_tready) begin
                busy = 1'b1;
                n_in++;
                d = body_inflight.pop_front();
                unescape_predict(s_tdata, s_tlast);
                if (d.fixed) begin
                    r = '{data: d.want_data, status: d.want_status, last: 1'b1};
                    utf8_due.insert(utf8_due.size(), r);
                end else begin
                    foreach (decoded[i]) begin
                        r      = decoded[i];
                        r.last = (i == decoded.size() - 1);
                        utf8_due.insert(utf8_due.size(), r);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                busy = 1'b1;
                n_out++;
                if (m_tuser == ST_CLOSE)   n_close++;
                if (m_tuser == ST_BAD_ESC) n_bad++;
                if (m_tuser == ST_UNTERM)  n_unterm++;
                if (utf8_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat data=%02h status=%0d last=%0d",
                                              m_tdata, m_tuser, m_tlast));
                end else begin
                    r = utf8_due.pop_front();
                    if (m_tdata !== r.data)
                        report_mismatch($sformatf("beat %0d data %02h, want %02h",
                                                  n_out, m_tdata, r.data));
                    if (m_tuser !== r.status)
                        report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                                  n_out, m_tuser, r.status));
                    if (m_tlast !== r.last)
                        report_mismatch($sformatf("beat %0d last %0d, want %0d",
                                                  n_out, m_tlast, r.last));
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: too long with no beat on either side
    initial begin : watchdog
        wait (aresetn);
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = hold_req ? HOLD_CYCLES : pick_gap();
            if (hold_req) n_holds++;
            hold_req = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat (calm ? $urandom_range(20, 60) : $urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic offer(input stim_t d);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        body_inflight.insert(body_inflight.size(), d);
        s_tvalid <= 1'b1;
        s_tdata  <= d.data;
        s_tlast  <= d.eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_offered++;
        calm_left--;
        if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(10, 40);
        end
    endtask

    function automatic stim_t raw(input logic [7:0] b);
        return '{data: b, eoi: 1'b0, fixed: 1'b0, want_data: 8'h00, want_status: ST_DATA};
    endfunction

    function automatic stim_t chk(input logic [7:0] b, input logic e,
                                  input logic [7:0] w, input status_t st);
        return '{data: b, eoi: e, fixed: 1'b1, want_data: w, want_status: st};
    endfunction

    task automatic put_byte(input logic [7:0] b);
        offer(raw(b));
    endtask

    // end of text; the byte lane carries junk
    task automatic put_end();
        offer('{data: 8'($urandom), eoi: 1'b1, fixed: 1'b0, want_data: 8'h00,
                want_status: ST_DATA});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;  // mixed case
    endfunction

    task automatic put_uescape(input logic [15:0] v);
        put_byte(CHR_BSLASH);
        put_byte(CHR_U);
        for (int i = 3; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CHR_QUOTE || b == CHR_BSLASH) b = b ^ 8'h01;
        return b;
    endfunction

    function automatic logic [15:0] high_sur();
        return 16'hD800 | 16'($urandom_range(0, 1023));
    endfunction

    // pause the sender until every predicted result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (utf8_due.size() != 0) @(posedge aclk);
    endtask

    // one random fragment of a string body
    task automatic random_token();
        int unsigned pick;
        logic [15:0] cp;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            put_byte(plain_char());
        end else if (pick < 40) begin
            put_byte(CHR_BSLASH);
            put_byte(esc_chars[$urandom_range(0, 7)]);
        end else if (pick < 44) begin
            // escape with any byte, unknown ones mostly
            put_byte(CHR_BSLASH);
            put_byte(8'($urandom));
        end else if (pick < 58) begin
            case ($urandom_range(0, 2))
                0:       cp = 16'($urandom_range(0, 16'h7F));
                1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
                default: cp = 16'($urandom);
            endcase
            put_uescape(cp);
        end else if (pick < 68) begin
            put_uescape(high_sur());
            put_uescape(16'hDC00 | 16'($urandom_range(0, 1023)));
        end else if (pick < 73) begin
            // high surrogate not followed by a low one
            put_uescape(high_sur());
            case ($urandom_range(0, 3))
                0: put_byte(plain_char());
                1: put_byte(CHR_QUOTE);
                2: begin
                    put_byte(CHR_BSLASH);
                    put_byte($urandom_range(0, 1) ? esc_chars[$urandom_range(0, 7)] : 8'h78);
                end
                default: begin
                    cp = 16'($urandom);
                    if (cp[15:10] == 6'b110111) cp[10] = 1'b0;
                    put_uescape(cp);
                end
            endcase
        end else if (pick < 76) begin
            put_uescape(16'hDC00 | 16'($urandom_range(0, 1023)));
        end else if (pick < 80) begin
            put_byte(CHR_QUOTE);
        end else if (pick < 83) begin
            // bad hex digit, sometimes in the second escape of a pair
            if ($urandom_range(0, 1)) put_uescape(high_sur());
            put_byte(CHR_BSLASH);
            put_byte(CHR_U);
            repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom)));
            b = 8'($urandom);
            if (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) b = 8'h7A;
            put_byte(b);
        end else if (pick < 86) begin
            case ($urandom_range(0, 3))
                0: ;
                1: put_byte(CHR_BSLASH);
                2: begin
                    put_byte(CHR_BSLASH);
                    put_byte(CHR_U);
                    repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom)));
                end
                default: put_uescape(high_sur());
            endcase
            put_end();
        end else begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        stim_t plan [N_PLAN];
        logic  paused_mid;
        paused_mid = 1'b0;
        esc_chars  = '{CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_B, CHR_F, CHR_N, CHR_R, CHR_T};
        plan = '{
            chk("A", 1'b0, "A", ST_DATA),               // first byte after reset
            chk(8'h00, 1'b0, 8'h00, ST_DATA),           // byte extremes
            chk(8'hFF, 1'b0, 8'hFF, ST_DATA),
            raw(CHR_BSLASH), chk(CHR_N, 1'b0, 8'h0A, ST_DATA),
            raw(CHR_BSLASH), raw("q"),                  // unknown escape, two bytes
            // \uDBfF: top high surrogate, held
            raw(CHR_BSLASH), raw(CHR_U), raw("D"), raw("B"), raw("f"), raw("F"),
            // \udC00: lowest low surrogate, pair gives four bytes
            raw(CHR_BSLASH), raw(CHR_U), raw("d"), raw("C"), raw("0"), raw("0"),
            // end of text inside \u, byte lane all ones
            raw(CHR_BSLASH), raw(CHR_U), chk(8'hFF, 1'b1, 8'h00, ST_BAD_ESC),
            // non-hex digit inside \u
            raw(CHR_BSLASH), raw(CHR_U), chk("g", 1'b0, 8'h00, ST_BAD_ESC),
            chk(CHR_QUOTE, 1'b0, 8'h00, ST_CLOSE),
            chk(8'h00, 1'b1, 8'h00, ST_UNTERM)          // end of text, plain phase
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) offer(plan[i]);
        drain();

        // receiver holds off while the sender keeps offering
        hold_req  = 1'b1;
        calm      = 1'b1;
        calm_left = 60;
        while (n_offered < N_PLAN + RANDOM_BEATS) begin
            random_token();
            if (!paused_mid && n_offered >= N_PLAN + RANDOM_BEATS / 2) begin
                drain();
                paused_mid = 1'b1;
            end
        end
        drain();
        repeat (16) @(posedge aclk);   // stray results would show up here

        $display("covered %0d input beats and %0d result beats: %0d closes, %0d bad escapes,",
                 n_in, n_out, n_close, n_bad);
        $display("%0d unterminated, %0d surrogate pairs, %0d long hold-offs; %0d mismatches",
                 n_unterm, n_pairs, n_holds, n_errors);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
